// File: rtl/core/dcl_pkg.sv
// Shared types and constants for the de Casteljau level evaluator.
// Holds the item mode codes and the controller-to-datapath command group.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package dcl_pkg;

  localparam int unsigned MAX_POINTS_DEF = 8;
  localparam int unsigned COORD_BITS_DEF = 24;

  localparam int unsigned T_BITS = 17;
  localparam logic [T_BITS-1:0] T_ONE = 17'h10000;
  localparam int ROUND_HALF = 32768;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_EVAL   = 2'd2
  } dcl_mode_e;

  typedef struct packed {
    logic load;   // write the item's point into the store
    logic eval;   // copy the store into the work queue, latch t
    logic shift;  // pop the queue head
    logic push;   // append the interpolated point at the queue tail
  } dcl_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/dcl_datapath.sv
// Datapath: control point store, work queue and the x/y interpolation units.
// Driven by dcl_ctrl through dcl_cmd_t; uses dcl_pkg.
`default_nettype none

module dcl_datapath import dcl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire dcl_cmd_t                     cmd_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_idx_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0] push_idx_i,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic [T_BITS-1:0]            param_t_i,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  logic signed [CW-1:0] sx_q [MAX_POINTS];
  logic signed [CW-1:0] sy_q [MAX_POINTS];
  logic signed [CW-1:0] wx_q [MAX_POINTS];
  logic signed [CW-1:0] wy_q [MAX_POINTS];
  logic signed [CW-1:0] shx  [MAX_POINTS];
  logic signed [CW-1:0] shy  [MAX_POINTS];
  logic [T_BITS-1:0]    t_q;
  logic [T_BITS-1:0]    t_sat;
  logic signed [CW-1:0] new_x;
  logic signed [CW-1:0] new_y;

  // a + floor((t*(b-a) + 1/2)), result always between a and b
  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic [T_BITS-1:0]    t);
    logic signed [CW:0]    d;
    logic signed [CW+18:0] p;
    logic signed [CW+2:0]  q;
    logic signed [CW+2:0]  s;
    d = {b[CW-1], b} - {a[CW-1], a};
    p = $signed({1'b0, t}) * d + (CW+19)'(ROUND_HALF);
    q = p[CW+18:16];
    s = {{3{a[CW-1]}}, a} + q;
    return s[CW-1:0];
  endfunction

  assign t_sat = (param_t_i > T_ONE) ? T_ONE : param_t_i;
  assign new_x = lerp(wx_q[0], wx_q[1], t_q);
  assign new_y = lerp(wy_q[0], wy_q[1], t_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q[wr_idx_i] <= point_x_i;
      sy_q[wr_idx_i] <= point_y_i;
    end
    if (cmd_i.eval) begin
      t_q <= t_sat;
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_queue
    if (k < MAX_POINTS - 1) begin : g_mid
      assign shx[k] = wx_q[k+1];
      assign shy[k] = wy_q[k+1];
    end else begin : g_end
      assign shx[k] = wx_q[k];
      assign shy[k] = wy_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.eval) begin
        wx_q[k] <= sx_q[k];
        wy_q[k] <= sy_q[k];
      end else if (cmd_i.shift) begin
        if (cmd_i.push && (push_idx_i == IDX_W'(k))) begin
          wx_q[k] <= new_x;
          wy_q[k] <= new_y;
        end else begin
          wx_q[k] <= shx[k];
          wy_q[k] <= shy[k];
        end
      end
    end
  end

  assign out_x_o = wx_q[0];
  assign out_y_o = wy_q[0];

endmodule

`default_nettype wire

// File: rtl/core/dcl_ctrl.sv
// Controller: point count, evaluation sequencer and result tagging.
// Issues dcl_cmd_t to dcl_datapath; uses dcl_pkg.
`default_nettype none

module dcl_ctrl import dcl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [1:0]                    mode_i,
  output logic                               busy_o,
  output dcl_cmd_t                           cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0]      wr_idx_o,
  output logic [$clog2(MAX_POINTS)-1:0]      push_idx_o,
  output logic                               result_valid_o,
  output logic [2:0]                         level_o,
  output logic [2:0]                         index_o,
  output logic                               last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] nm1;
  logic [IDX_W-1:0] i_q;
  logic [IDX_W-1:0] lvl_q;
  dcl_mode_e        mode;
  logic             take;
  logic             not_full;
  logic             level_end;

  assign mode      = dcl_mode_e'(mode_i);
  assign take      = (state_q == ST_IDLE) && start_i;
  assign not_full  = count_q < CNT_W'(MAX_POINTS);
  assign nm1       = n_q - CNT_W'(1);
  assign level_end = (i_q == nm1[IDX_W-1:0]);

  always_comb begin
    cmd_o.load  = take && ((mode == MODE_LOAD) || ((mode == MODE_APPEND) && not_full));
    cmd_o.eval  = take && (mode == MODE_EVAL) && (count_q != '0);
    cmd_o.shift = (state_q == ST_EVAL) && (n_q != CNT_W'(1));
    cmd_o.push  = (state_q == ST_EVAL) && !level_end;
    wr_idx_o    = (mode == MODE_LOAD) ? '0 : count_q[IDX_W-1:0];
    push_idx_o  = nm1[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      n_q     <= '0;
      i_q     <= '0;
      lvl_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            case (mode)
              MODE_LOAD: begin
                count_q <= CNT_W'(1);
              end
              MODE_APPEND: begin
                if (not_full) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              MODE_EVAL: begin
                if (count_q != '0) begin
                  state_q <= ST_EVAL;
                  n_q     <= count_q;
                  i_q     <= '0;
                  lvl_q   <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EVAL: begin
          if (!level_end) begin
            i_q <= i_q + IDX_W'(1);
          end else if (n_q == CNT_W'(1)) begin
            state_q <= ST_IDLE;
          end else begin
            n_q   <= nm1;
            i_q   <= '0;
            lvl_q <= lvl_q + IDX_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_EVAL);
  assign last_o         = (state_q == ST_EVAL) && (n_q == CNT_W'(1));
  assign level_o        = 3'(lvl_q);
  assign index_o        = 3'(i_q);

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy_o)
    else $error("still busy after the final result");

  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> result_valid_o)
    else $error("gap inside an evaluation's result burst");

  a_index_in_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((CNT_W'(i_q) < n_q) && (n_q <= count_q)))
    else $error("result index outside its level");
`endif

endmodule

`default_nettype wire

// File: rtl/core/de_casteljau_levels.sv
// A load item (mode 0 or 1) is written at the accepting edge and leaves busy_o low.
// Evaluate with n points: first result in the cycle after the accepting edge, then
// n*(n+1)/2 results on consecutive cycles; busy_o drops at the edge taking the last.
// Throughput: one load item per cycle; after an evaluate the next item is taken
// only once busy_o has dropped, which the burst of results holds off.
// Reset (rst_ni, async, active low) clears count and sequencer, not the point store.
`default_nettype none

module de_casteljau_levels import dcl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // item command port
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic [T_BITS-1:0]            param_t_i,
  // result strobe port
  output logic                              result_valid_o,
  output logic [2:0]                        level_o,
  output logic [2:0]                        index_o,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o,
  output logic                              last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);

  // Command group from the sequencer to the datapath.
  dcl_cmd_t         cmd;
  // Store write slot: zero for a fresh set, the current count for an append.
  logic [IDX_W-1:0] wr_idx;
  // Queue tail slot for the freshly interpolated point (level size minus one).
  logic [IDX_W-1:0] push_idx;

  // The sequencer walks each level: every cycle it shows the queue head,
  // and while the level has a right neighbor it pushes lerp(head, next)
  // to the tail, so the next level builds up behind the current one.
  dcl_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .mode_i         (mode_i),
    .busy_o         (busy_o),
    .cmd_o          (cmd),
    .wr_idx_o       (wr_idx),
    .push_idx_o     (push_idx),
    .result_valid_o (result_valid_o),
    .level_o        (level_o),
    .index_o        (index_o),
    .last_o         (last_o)
  );

  // Store, work queue and the two interpolators; the queue head is the result.
  dcl_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .wr_idx_i   (wr_idx),
    .push_idx_i (push_idx),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .param_t_i  (param_t_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o)
  );

endmodule

`default_nettype wire

// File: bench/de_casteljau_levels_checker.sv
// Result checker for the de Casteljau level evaluator bench.
// Watches the item and result ports, predicts every level point, compares in order.
// Depends on dcl_pkg for the mode codes, t constants and default sizes.
module de_casteljau_levels_checker import dcl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [1:0]                   mode_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [T_BITS-1:0]            param_t_i,
  input  logic                         result_valid_i,
  input  logic [2:0]                   level_i,
  input  logic [2:0]                   index_i,
  input  logic signed [COORD_BITS-1:0] out_x_i,
  input  logic signed [COORD_BITS-1:0] out_y_i,
  input  logic                         last_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [2:0] level;
    logic [2:0] index;
    coord_t     x;
    coord_t     y;
    logic       last;
  } curve_point_t;

  coord_t       ctrl_x [MAX_POINTS];
  coord_t       ctrl_y [MAX_POINTS];
  int unsigned  ctrl_count;
  curve_point_t curve_points [$];

  // a + t*(b - a), rounded to nearest with ties toward plus infinity
  function automatic longint blend(longint a, longint b, longint t);
    longint p;
    p = t * (b - a) + ROUND_HALF;
    return a + (p >>> 16);
  endfunction

  task automatic predict_levels(input logic [T_BITS-1:0] t_in);
    longint       wx [MAX_POINTS];
    longint       wy [MAX_POINTS];
    longint       t;
    int           n;
    int           lvl;
    int           i;
    curve_point_t pt;
    t = (t_in > T_ONE) ? longint'(T_ONE) : longint'(t_in);
    for (i = 0; i < int'(ctrl_count); i++) begin
      wx[i] = ctrl_x[i];
      wy[i] = ctrl_y[i];
    end
    n = ctrl_count;
    lvl = 0;
    while (n > 0) begin
      for (i = 0; i < n; i++) begin
        pt.level = lvl[2:0];
        pt.index = i[2:0];
        pt.x     = wx[i][COORD_BITS-1:0];
        pt.y     = wy[i][COORD_BITS-1:0];
        pt.last  = (n == 1);
        curve_points = {curve_points, pt};
      end
      for (i = 0; i + 1 < n; i++) begin
        wx[i] = blend(wx[i], wx[i+1], t);
        wy[i] = blend(wy[i], wy[i+1], t);
      end
      n--;
      lvl++;
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors_o++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_point();
    curve_point_t want;
    if (curve_points.size() == 0) begin
      errors_o++;
      $display("%0t: unexpected result: expected none, got level %0d index %0d x %0d y %0d",
               $time, level_i, index_i, out_x_i, out_y_i);
    end else begin
      want = curve_points.pop_front();
      checked_o++;
      compare_field("level", want.level, level_i);
      compare_field("index", want.index, index_i);
      compare_field("out_x", want.x, out_x_i);
      compare_field("out_y", want.y, out_y_i);
      compare_field("last", want.last, last_i);
    end
  endtask

  // Check results before taking a new item: a result at this edge is always older.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      ctrl_count = 0;
      curve_points.delete();
    end else begin
      if (result_valid_i)
        check_point();
      if (start_i && !busy_i) begin
        case (mode_i)
          MODE_LOAD, MODE_APPEND: begin
            if (mode_i == MODE_LOAD)
              ctrl_count = 0;
            if (ctrl_count < MAX_POINTS) begin
              ctrl_x[ctrl_count] = point_x_i;
              ctrl_y[ctrl_count] = point_y_i;
              ctrl_count++;
            end
          end
          MODE_EVAL: begin
            if (ctrl_count != 0)
              predict_levels(param_t_i);
          end
          default: ;
        endcase
      end
    end
    pending_o = curve_points.size();
  end

endmodule

// File: bench/de_casteljau_levels_tb.sv
// Top of the de Casteljau level evaluator bench: clock, reset, item stimulus, verdict.
// Drives directed and random point loads and evaluations through the command port.
// Depends on dcl_pkg, the block itself and de_casteljau_levels_checker.
module de_casteljau_levels_tb import dcl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_POINTS  = MAX_POINTS_DEF;
  localparam int unsigned COORD_BITS  = COORD_BITS_DEF;
  localparam int          PHASE_ITEMS = 24;
  localparam int          TAIL_CYCLES = 40;

  // mode 3 has no member in the package; the block must drop it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          mode_i;
  coord_t              point_x_i;
  coord_t              point_y_i;
  logic [T_BITS-1:0]   param_t_i;
  logic                result_valid_o;
  logic [2:0]          level_o;
  logic [2:0]          index_o;
  coord_t              out_x_o;
  coord_t              out_y_o;
  logic                last_o;

  int errors;
  int pending;
  int checked;

  // stimulus bookkeeping
  int idle_pct;
  int store_fill;
  int counted_items;
  int eval_items;
  int idle_mix [3] = '{0, 81, 28};

  always #5 clk_i = ~clk_i;

  de_casteljau_levels #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .param_t_i      (param_t_i),
    .result_valid_o (result_valid_o),
    .level_o        (level_o),
    .index_o        (index_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .last_o         (last_o)
  );

  de_casteljau_levels_checker #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) level_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .mode_i         (mode_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .param_t_i      (param_t_i),
    .result_valid_i (result_valid_o),
    .level_i        (level_o),
    .index_i        (index_o),
    .out_x_i        (out_x_o),
    .out_y_i        (out_y_o),
    .last_i         (last_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Mix rail values, small coordinates (short interpolation steps) and full-range noise.
  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return coord_t'(int'($urandom_range(8191)) - 4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Favor t within [0, one]; sometimes use the whole 17-bit field to hit saturation.
  function automatic logic [T_BITS-1:0] rand_t();
    case ($urandom_range(9))
      0:       return '0;
      1:       return T_ONE;
      2:       return T_BITS'($urandom);
      3:       return T_BITS'($urandom_range(1, 3));
      default: return T_BITS'($urandom_range(0, 65536));
    endcase
  endfunction

  // Present one item at a falling edge, idling first as the phase asks, and hold it
  // until a rising edge sees busy low. Scramble the fields while start is low.
  task automatic send_item(input logic [1:0] mode, input coord_t x, input coord_t y,
                           input logic [T_BITS-1:0] t);
    logic ignored;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i   = 1'b0;
      mode_i    = 2'($urandom);
      point_x_i = coord_t'($urandom);
      point_y_i = coord_t'($urandom);
      param_t_i = T_BITS'($urandom);
      @(negedge clk_i);
    end
    start_i   = 1'b1;
    mode_i    = mode;
    point_x_i = x;
    point_y_i = y;
    param_t_i = t;
    do @(posedge clk_i); while (busy_o);
    // track the fill level so that dropped items are not counted
    ignored = (mode == MODE_UNUSED) || (mode == MODE_APPEND && store_fill == MAX_POINTS);
    if (mode == MODE_LOAD)
      store_fill = 1;
    else if (mode == MODE_APPEND && !ignored)
      store_fill++;
    if (mode == MODE_EVAL)
      eval_items++;
    if (!ignored)
      counted_items++;
  endtask

  // Drop start and wait until every predicted point has come out and the block is surely idle.
  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int start_count;
    int pick;
    int n;
    int k;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    mode_i        = MODE_LOAD;
    point_x_i     = '0;
    point_y_i     = '0;
    param_t_i     = '0;
    idle_pct      = 0;
    store_fill    = 0;
    counted_items = 0;
    eval_items    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, back to back.
    // Evaluate with an empty store: expect nothing.
    send_item(MODE_EVAL, '0, '0, T_BITS'(32768));
    // Unused mode: drop it.
    send_item(MODE_UNUSED, COORD_MAX, COORD_MIN, '1);
    // Append into an empty store, then evaluate a single point.
    send_item(MODE_APPEND, COORD_MAX, COORD_MIN, '0);
    send_item(MODE_EVAL, '0, '0, '0);
    // Fill the store, mostly with rail values, so that most differences are as wide as possible.
    send_item(MODE_LOAD, COORD_MIN, COORD_MAX, '0);
    send_item(MODE_APPEND, COORD_MAX, COORD_MIN, '0);
    send_item(MODE_APPEND, COORD_MIN, COORD_MAX, '0);
    send_item(MODE_APPEND, COORD_MAX, COORD_MIN, '0);
    send_item(MODE_APPEND, '0, '1, '0);
    send_item(MODE_APPEND, coord_t'(1), '0, '0);
    send_item(MODE_APPEND, COORD_MAX, COORD_MAX, '0);
    send_item(MODE_APPEND, COORD_MIN, COORD_MIN, '0);
    // Store full: this append must be dropped.
    send_item(MODE_APPEND, coord_t'(12345), coord_t'(-777), '0);
    // t at one, zero, above one (saturates), smallest step, half.
    send_item(MODE_EVAL, '0, '0, T_ONE);
    send_item(MODE_EVAL, '0, '0, '0);
    send_item(MODE_EVAL, '0, '0, '1);
    send_item(MODE_EVAL, '0, '0, T_BITS'(1));
    send_item(MODE_EVAL, '0, '0, T_BITS'(32768));
    // Rounding ties: odd differences at t one half, both signs; then the same set with t just above one.
    send_item(MODE_LOAD, '1, coord_t'(1), '0);
    send_item(MODE_APPEND, '0, '1, '0);
    send_item(MODE_APPEND, coord_t'(3), coord_t'(-4), '0);
    send_item(MODE_EVAL, '0, '0, T_BITS'(32768));
    send_item(MODE_EVAL, '0, '0, T_ONE + 1'b1);
    // Let every result out before the random part starts.
    drain_results();

    // Random part: mostly full load-then-evaluate sequences, plus stray appends,
    // evaluations on the current set and unused-mode noise.
    foreach (idle_mix[ph]) begin
      idle_pct = idle_mix[ph];
      start_count = counted_items;
      while (counted_items - start_count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          if ($urandom_range(7) == 0)
            drain_results();
          n = $urandom_range(1, MAX_POINTS);
          if ($urandom_range(9) == 0)
            n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 2);
          send_item(MODE_LOAD, rand_coord(), rand_coord(), rand_t());
          for (k = 1; k < n; k++)
            send_item(MODE_APPEND, rand_coord(), rand_coord(), rand_t());
          repeat ($urandom_range(1, 3))
            send_item(MODE_EVAL, rand_coord(), rand_coord(), rand_t());
        end else if (pick < 85) begin
          send_item(MODE_APPEND, rand_coord(), rand_coord(), rand_t());
        end else if (pick < 93) begin
          send_item(MODE_EVAL, rand_coord(), rand_coord(), rand_t());
        end else begin
          send_item(MODE_UNUSED, rand_coord(), rand_coord(), rand_t());
        end
      end
      drain_results();
    end

    // Catch stray results after the last expected one.
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Covered %0d items (%0d evaluations) with sender idling at 0, 81 and 28 percent;",
             counted_items, eval_items);
    $display("%0d level points compared, %0d mismatches, %0d still outstanding.",
             checked, errors, pending);
    if (errors == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: de_casteljau_levels.f
rtl/core/dcl_pkg.sv
rtl/core/dcl_datapath.sv
rtl/core/dcl_ctrl.sv
rtl/core/de_casteljau_levels.sv
bench/de_casteljau_levels_checker.sv
bench/de_casteljau_levels_tb.sv
